### sv/tbb_pkg.sv
// Package for the transformed bounding box unit: widths, register indexes,
// product and sum types, and the Q16.16 floor-and-saturate helper.
// No dependencies.
package tbb_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumRegs   = 6;
  localparam int unsigned ProdW     = 2 * CoordW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned BoxW      = 2 * NumAxes * CoordW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRow0Cols01 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRow0Cols23 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRow1Cols01 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRow1Cols23 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRow2Cols01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRow2Cols23 = 3'd5;

  // Reset values give the identity transform
  localparam logic [CfgW-1:0] ResetRow0Cols01 = 64'h0000_0000_0001_0000;
  localparam logic [CfgW-1:0] ResetRow1Cols01 = 64'h0001_0000_0000_0000;
  localparam logic [CfgW-1:0] ResetRow2Cols23 = 64'h0000_0000_0001_0000;
  localparam logic [CfgW-1:0] ResetZero       = 64'h0;

  localparam logic [CoordW-1:0] CoordMax = 32'h7fff_ffff;
  localparam logic [CoordW-1:0] CoordMin = 32'h8000_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;

  // Floor a Q34.32 sum to Q16.16 and clamp to the signed 32-bit range
  function automatic logic [CoordW-1:0] floor_sat(input sum_t s);
    logic [SumW-FracBits-1:0] f;
    logic [SumW-FracBits-CoordW:0] top;
    f   = s[SumW-1:FracBits];
    top = f[SumW-FracBits-1:CoordW-1];
    if ((&top) || !(|top)) begin
      return f[CoordW-1:0];
    end else if (f[SumW-FracBits-1]) begin
      return CoordMin;
    end else begin
      return CoordMax;
    end
  endfunction

endpackage

### sv/transformed_bounding_box_unit.sv
// Transformed bounding box unit: affine transform of an axis-aligned box.
// Depends on tbb_pkg.
//
// Takes one box per cycle when not stalled (min and max corners, signed
// Q16.16) and returns the axis-aligned bound of its eight corners after the
// top three rows of the configured affine matrix, floored to Q16.16 and
// saturated to 32 bits. Output valid rises when the box reaches the
// output register; throughput, unless stalled, is one box per cycle. The
// work is split over four register stages: 18 parallel 32x32 multipliers
// (each matrix entry times the box min and max), a per-term min/max pick, a
// three-term sum plus translation, and floor/saturate into the output
// register. Since each row is a sum of independent terms, the corner
// minimum is the sum of per-term minimums (likewise for maximum), so no
// corner enumeration is needed. The user writes matrix registers through
// the cfg port only while the unit is idle; the block does not enforce it,
// accepts every write and ignores indexes beyond the last register.
module transformed_bounding_box_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tbb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tbb_pkg::CfgW-1:0]      cfg_data_i,
  // box input, tdata low to high: min_x, min_y, min_z, max_x, max_y, max_z
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tbb_pkg::BoxW-1:0]      s_axis_tdata,
  // box output, tdata low to high: out_min_x, out_min_y, out_min_z,
  // out_max_x, out_max_y, out_max_z
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tbb_pkg::BoxW-1:0]      m_axis_tdata
);
  import tbb_pkg::*;

  // Matrix registers
  logic [CfgW-1:0] cfg_q [NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[RegRow0Cols01] <= ResetRow0Cols01;
      cfg_q[RegRow0Cols23] <= ResetZero;
      cfg_q[RegRow1Cols01] <= ResetRow1Cols01;
      cfg_q[RegRow1Cols23] <= ResetZero;
      cfg_q[RegRow2Cols01] <= ResetZero;
      cfg_q[RegRow2Cols23] <= ResetRow2Cols23;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRow0Cols01: cfg_q[RegRow0Cols01] <= cfg_data_i;
        RegRow0Cols23: cfg_q[RegRow0Cols23] <= cfg_data_i;
        RegRow1Cols01: cfg_q[RegRow1Cols01] <= cfg_data_i;
        RegRow1Cols23: cfg_q[RegRow1Cols23] <= cfg_data_i;
        RegRow2Cols01: cfg_q[RegRow2Cols01] <= cfg_data_i;
        RegRow2Cols23: cfg_q[RegRow2Cols23] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack matrix entries and translations
  coord_t mat [NumAxes][NumAxes];
  coord_t trans [NumAxes];

  always_comb begin
    for (int r = 0; r < NumAxes; r++) begin
      mat[r][0] = cfg_q[2*r][CoordW-1:0];
      mat[r][1] = cfg_q[2*r][CfgW-1:CoordW];
      mat[r][2] = cfg_q[2*r+1][CoordW-1:0];
      trans[r]  = cfg_q[2*r+1][CfgW-1:CoordW];
    end
  end

  // Stage handshake: each stage takes a word when empty or draining
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4          = !v4_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: every matrix entry times box min and max on its axis
  coord_t lo_in [NumAxes];
  coord_t hi_in [NumAxes];
  prod_t  plo_d [NumAxes][NumAxes];
  prod_t  phi_d [NumAxes][NumAxes];
  prod_t  plo_q [NumAxes][NumAxes];
  prod_t  phi_q [NumAxes][NumAxes];

  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      lo_in[k] = s_axis_tdata[k*CoordW +: CoordW];
      hi_in[k] = s_axis_tdata[(NumAxes+k)*CoordW +: CoordW];
    end
    for (int r = 0; r < NumAxes; r++) begin
      for (int k = 0; k < NumAxes; k++) begin
        plo_d[r][k] = prod_t'(mat[r][k]) * prod_t'(lo_in[k]);
        phi_d[r][k] = prod_t'(mat[r][k]) * prod_t'(hi_in[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  // Stage 2: per-term minimum and maximum
  prod_t pmin_q [NumAxes][NumAxes];
  prod_t pmax_q [NumAxes][NumAxes];

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      for (int r = 0; r < NumAxes; r++) begin
        for (int k = 0; k < NumAxes; k++) begin
          if (plo_q[r][k] < phi_q[r][k]) begin
            pmin_q[r][k] <= plo_q[r][k];
            pmax_q[r][k] <= phi_q[r][k];
          end else begin
            pmin_q[r][k] <= phi_q[r][k];
            pmax_q[r][k] <= plo_q[r][k];
          end
        end
      end
    end
  end

  // Stage 3: three-term sums plus translation in Q34.32
  sum_t smin_d [NumAxes];
  sum_t smax_d [NumAxes];
  sum_t smin_q [NumAxes];
  sum_t smax_q [NumAxes];
  sum_t tsum   [NumAxes];

  always_comb begin
    for (int r = 0; r < NumAxes; r++) begin
      tsum[r]   = sum_t'($signed({trans[r], {FracBits{1'b0}}}));
      smin_d[r] = sum_t'(pmin_q[r][0]) + sum_t'(pmin_q[r][1])
                + sum_t'(pmin_q[r][2]) + tsum[r];
      smax_d[r] = sum_t'(pmax_q[r][0]) + sum_t'(pmax_q[r][1])
                + sum_t'(pmax_q[r][2]) + tsum[r];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      smin_q <= smin_d;
      smax_q <= smax_d;
    end
  end

  // Stage 4: floor, saturate and pack into the output word
  logic [BoxW-1:0] out_d, out_q;

  always_comb begin
    for (int r = 0; r < NumAxes; r++) begin
      out_d[r*CoordW +: CoordW]           = floor_sat(smin_q[r]);
      out_d[(NumAxes+r)*CoordW +: CoordW] = floor_sat(smax_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tdata = out_q;

endmodule
